// ===== rtl/salc_pkg.sv =====
// Shared types and constants for the set-associative LRU cache model.
// No dependencies; used by salc_store and set_assoc_lru_cache_sim.
`timescale 1ns / 1ps
`default_nettype none

package salc_pkg;

    // Fixed field widths
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 64;
    localparam int OP_W       = 2;
    localparam int OUTCOME_W  = 2;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS       = 2'd2;

    // Operation codes (code three acts as a load)
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;

    // Access outcome codes
    localparam logic [OUTCOME_W-1:0] OUT_HIT   = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_MISS  = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_EVICT = 2'd2;

    // Write enables toward the line store
    typedef struct packed {
        logic tag;
        logic rank;
        logic row;
    } t_store_we;

endpackage

`default_nettype wire

// ===== rtl/set_assoc_lru_cache_sim.sv =====
// Set-associative cache with true LRU: one access per load/store, two per modify.
// Each access scans ways until a hit or the last way in use, then updates the rank of
// every way in use, through one shared tag/rank compare unit stepping one way at a time.
// The result strobe follows the last rank update; with an item's final strobe a new item is taken in that cycle.
// Reset (synchronous, active low) clears counters and config, then sweeps all
// 2**MAX_SET_BITS valid rows with busy high. Results cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 6,
    parameter int MAX_WAYS     = 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    // configuration write channel
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire  [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [salc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // command
    input  wire                             i_start,
    output logic                            o_busy,
    input  wire  [salc_pkg::OP_W-1:0]       i_operation,
    input  wire  [salc_pkg::ADDR_W-1:0]     i_address,
    // results
    output logic                            o_result_valid,
    output logic [salc_pkg::OUTCOME_W-1:0]  o_outcome,
    output logic                            o_last,
    output logic [salc_pkg::CNT_W-1:0]      o_hit_total,
    output logic [salc_pkg::CNT_W-1:0]      o_miss_total,
    output logic [salc_pkg::CNT_W-1:0]      o_evict_total
);

    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int RANK_W   = WAY_W;
    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int LINE_AW  = SET_W + WAY_W;

    typedef enum logic [7:0] {
        S_CLEAR    = 8'b0000_0001,
        S_IDLE     = 8'b0000_0010,
        S_SETUP    = 8'b0000_0100,
        S_SCAN_RD  = 8'b0000_1000,
        S_SCAN_CMP = 8'b0001_0000,
        S_DECIDE   = 8'b0010_0000,
        S_UPD_RD   = 8'b0100_0000,
        S_UPD_WR   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [2:0] r_set_bits;
    logic [5:0] r_block_bits;
    logic [3:0] r_ways;

    // item and access context
    logic [salc_pkg::OP_W-1:0]   r_op;
    logic [salc_pkg::ADDR_W-1:0] r_addr;
    logic                        r_second;
    logic [salc_pkg::TAG_W-1:0]  r_tag;
    logic [SET_W-1:0]            r_set;
    logic [WAY_W-1:0]            r_last_way;
    logic [WAY_W-1:0]            r_way;
    logic [SET_W-1:0]            r_clr;

    // scan results
    logic                           r_hit;
    logic [WAY_W-1:0]               r_hit_w;
    logic [RANK_W-1:0]              r_old;
    logic                           r_inv;
    logic [WAY_W-1:0]               r_inv_w;
    logic [RANK_W-1:0]              r_best;
    logic [WAY_W-1:0]               r_best_w;
    logic [WAY_W-1:0]               r_tgt;
    logic [salc_pkg::OUTCOME_W-1:0] r_outcome;

    // totals and result register
    logic [salc_pkg::CNT_W-1:0]     r_hit_cnt, r_miss_cnt, r_evict_cnt;
    logic                           r_res_vld;
    logic [salc_pkg::OUTCOME_W-1:0] r_res_outcome;
    logic                           r_res_last;

    // store interface
    salc_pkg::t_store_we        w_we;
    logic [salc_pkg::TAG_W-1:0] w_tag_q;
    logic [RANK_W-1:0]          w_rank_q;
    logic [MAX_WAYS-1:0]        w_row_q;
    logic [SET_W-1:0]           w_row_addr;
    logic [MAX_WAYS-1:0]        w_row_wdata;
    logic [RANK_W-1:0]          w_rank_wdata;

    // address decode and way count
    logic [3:0]                 w_sb;
    logic [6:0]                 w_tshift;
    logic [salc_pkg::TAG_W-1:0] w_tag;
    logic [SET_W-1:0]           w_set_mask;
    logic [SET_W-1:0]           w_set;
    logic [WAY_W-1:0]           w_last_way;

    // per-way evaluation
    logic                       w_cur_valid;
    logic                       w_match;
    logic                       w_scan_done;
    logic [WAY_W-1:0]           w_tgt;
    logic [MAX_WAYS-1:0]        w_tgt_bit;
    logic                       w_is_tgt;
    logic                       w_age;
    logic                       w_upd_done;
    logic                       w_more;

    assign o_cfg_ready    = 1'b1;
    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_res_vld;
    assign o_outcome      = r_res_outcome;
    assign o_last         = r_res_last;
    assign o_hit_total    = r_hit_cnt;
    assign o_miss_total   = r_miss_cnt;
    assign o_evict_total  = r_evict_cnt;

    // Address split: set bits clamp to the maximum, tag is zero for shifts past 63
    always_comb begin
        w_sb = (int'(r_set_bits) > MAX_SET_BITS) ? 4'(MAX_SET_BITS) : {1'b0, r_set_bits};
        w_tshift   = {3'b000, w_sb} + {1'b0, r_block_bits};
        w_tag      = (w_tshift >= 7'd64) ? '0 : (r_addr >> w_tshift[5:0]);
        w_set_mask = SET_W'((64'd1 << w_sb) - 64'd1);
        w_set      = SET_W'(r_addr >> r_block_bits) & w_set_mask;
    end

    // Ways in use minus one: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        priority if (r_ways == 4'd0) begin
            w_last_way = '0;
        end else if (int'(r_ways) > MAX_WAYS) begin
            w_last_way = WAY_W'(MAX_WAYS - 1);
        end else begin
            w_last_way = WAY_W'(r_ways - 4'd1);
        end
    end

    // Shared compare unit for the way under r_way
    always_comb begin
        w_cur_valid = w_row_q[r_way];
        w_match     = w_cur_valid && (w_tag_q == r_tag);
        w_scan_done = w_match || (r_way == r_last_way);
        w_tgt       = r_hit ? r_hit_w : (r_inv ? r_inv_w : r_best_w);
        w_tgt_bit   = MAX_WAYS'(1) << w_tgt;
        w_is_tgt    = (r_way == r_tgt);
        w_age       = w_cur_valid
                      && ((r_outcome != salc_pkg::OUT_HIT) || (w_rank_q < r_old))
                      && (w_rank_q < RANK_W'(MAX_WAYS - 1));
        w_rank_wdata = w_is_tgt ? '0 : RANK_W'(w_rank_q + 1'b1);
        w_upd_done  = (r_way == r_last_way);
        w_more      = (r_op == salc_pkg::OP_MODIFY) && !r_second;
    end

    // Store controls
    always_comb begin
        w_we.tag    = (r_state == S_DECIDE) && !r_hit;
        w_we.row    = (r_state == S_DECIDE) || (r_state == S_CLEAR);
        w_we.rank   = (r_state == S_UPD_WR) && (w_is_tgt || w_age);
        w_row_addr  = (r_state == S_CLEAR) ? r_clr : r_set;
        w_row_wdata = (r_state == S_CLEAR) ? '0 : (w_row_q | w_tgt_bit);
    end

    salc_store #(
        .SET_W    (SET_W),
        .LINE_AW  (LINE_AW),
        .MAX_WAYS (MAX_WAYS),
        .RANK_W   (RANK_W),
        .NUM_SETS (NUM_SETS)
    ) u_store (
        .i_clk        (i_clk),
        .i_we         (w_we),
        .i_line_raddr ({r_set, r_way}),
        .o_tag        (w_tag_q),
        .o_rank       (w_rank_q),
        .i_tag_waddr  ({r_set, w_tgt}),
        .i_tag_wdata  (r_tag),
        .i_rank_waddr ({r_set, r_way}),
        .i_rank_wdata (w_rank_wdata),
        .i_row_addr   (w_row_addr),
        .i_row_wdata  (w_row_wdata),
        .o_row        (w_row_q)
    );

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR:    if (r_clr == SET_W'(NUM_SETS - 1)) n_state = S_IDLE;
            S_IDLE:     if (i_start) n_state = S_SETUP;
            S_SETUP:    n_state = S_SCAN_RD;
            S_SCAN_RD:  n_state = S_SCAN_CMP;
            S_SCAN_CMP: n_state = w_scan_done ? S_DECIDE : S_SCAN_RD;
            S_DECIDE:   n_state = S_UPD_RD;
            S_UPD_RD:   n_state = S_UPD_WR;
            S_UPD_WR: begin
                if (!w_upd_done) begin
                    n_state = S_UPD_RD;
                end else begin
                    n_state = w_more ? S_SETUP : S_IDLE;
                end
            end
            default:    n_state = S_CLEAR;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_set_bits   <= 3'd0;
            r_block_bits <= 6'd0;
            r_ways       <= 4'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                salc_pkg::CFG_SET_BITS:   r_set_bits   <= i_cfg_data[2:0];
                salc_pkg::CFG_BLOCK_BITS: r_block_bits <= i_cfg_data[5:0];
                salc_pkg::CFG_WAYS:       r_ways       <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Access datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_op     <= i_operation;
                r_addr   <= i_address;
                r_second <= 1'b0;
            end
            S_SETUP: begin
                r_tag      <= w_tag;
                r_set      <= w_set;
                r_last_way <= w_last_way;
                r_way      <= '0;
                r_hit      <= 1'b0;
                r_inv      <= 1'b0;
                r_best     <= '0;
                r_best_w   <= '0;
            end
            S_SCAN_CMP: begin
                if (w_match) begin
                    r_hit   <= 1'b1;
                    r_hit_w <= r_way;
                    r_old   <= w_rank_q;
                end
                if (!w_cur_valid && !r_inv) begin
                    r_inv   <= 1'b1;
                    r_inv_w <= r_way;
                end
                // strictly larger rank wins, so the lowest way takes a tie
                if (w_cur_valid && (w_rank_q > r_best)) begin
                    r_best   <= w_rank_q;
                    r_best_w <= r_way;
                end
                if (!w_scan_done) begin
                    r_way <= r_way + 1'b1;
                end
            end
            S_DECIDE: begin
                r_tgt     <= w_tgt;
                r_way     <= '0;
                r_outcome <= r_hit ? salc_pkg::OUT_HIT
                           : (r_inv ? salc_pkg::OUT_MISS : salc_pkg::OUT_EVICT);
            end
            S_UPD_WR: begin
                if (!w_upd_done) begin
                    r_way <= r_way + 1'b1;
                end else if (w_more) begin
                    r_second <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    // Totals and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            r_res_vld   <= 1'b0;
        end else begin
            r_res_vld <= 1'b0;
            if ((r_state == S_UPD_WR) && w_upd_done) begin
                r_res_vld <= 1'b1;
                if (r_outcome == salc_pkg::OUT_HIT) begin
                    r_hit_cnt <= r_hit_cnt + 1'b1;
                end else begin
                    r_miss_cnt <= r_miss_cnt + 1'b1;
                end
                if (r_outcome == salc_pkg::OUT_EVICT) begin
                    r_evict_cnt <= r_evict_cnt + 1'b1;
                end
            end
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if ((r_state == S_UPD_WR) && w_upd_done) begin
            r_res_outcome <= r_outcome;
            r_res_last    <= !w_more;
        end
    end

    // Checks
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held longer than one cycle");

    a_modify_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && !o_last) |=> o_busy)
        else $error("block idle between the two accesses of a modify");

    a_hit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && (o_outcome == salc_pkg::OUT_HIT))
            |-> (o_hit_total == $past(o_hit_total) + 1'b1))
        else $error("hit total did not advance on a hit");

    a_evict_is_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && (o_evict_total != $past(o_evict_total)))
            |-> (o_miss_total != $past(o_miss_total)))
        else $error("eviction counted without a miss");

endmodule

`default_nettype wire

// ===== rtl/salc_store.sv =====
// Line storage: tag and recency rank per line, valid bits per set row.
// Depends on salc_pkg for the tag width and the write-enable struct.
`timescale 1ns / 1ps
`default_nettype none

module salc_store #(
    parameter int SET_W    = 6,
    parameter int LINE_AW  = 9,
    parameter int MAX_WAYS = 8,
    parameter int RANK_W   = 3,
    parameter int NUM_SETS = 64
) (
    input  wire                        i_clk,
    input  wire salc_pkg::t_store_we   i_we,
    input  wire  [LINE_AW-1:0]         i_line_raddr,
    output logic [salc_pkg::TAG_W-1:0] o_tag,
    output logic [RANK_W-1:0]          o_rank,
    input  wire  [LINE_AW-1:0]         i_tag_waddr,
    input  wire  [salc_pkg::TAG_W-1:0] i_tag_wdata,
    input  wire  [LINE_AW-1:0]         i_rank_waddr,
    input  wire  [RANK_W-1:0]          i_rank_wdata,
    input  wire  [SET_W-1:0]           i_row_addr,
    input  wire  [MAX_WAYS-1:0]        i_row_wdata,
    output logic [MAX_WAYS-1:0]        o_row
);

    localparam int LINES = 1 << LINE_AW;

    logic [salc_pkg::TAG_W-1:0] tag_mem  [LINES];
    logic [RANK_W-1:0]          rank_mem [LINES];
    logic [MAX_WAYS-1:0]        row_mem  [NUM_SETS];

    // Tag memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_we.tag) begin
            tag_mem[i_tag_waddr] <= i_tag_wdata;
        end
        o_tag <= tag_mem[i_line_raddr];
    end

    // Rank memory: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (i_we.rank) begin
            rank_mem[i_rank_waddr] <= i_rank_wdata;
        end
        o_rank <= rank_mem[i_line_raddr];
    end

    // Valid rows: read and write share the row address, read returns old data
    always_ff @(posedge i_clk) begin
        if (i_we.row) begin
            row_mem[i_row_addr] <= i_row_wdata;
        end
        o_row <= row_mem[i_row_addr];
    end

endmodule

`default_nettype wire

// ===== tb/salc_access_checker.sv =====
// Access checker for the set-associative LRU cache: mirrors the config writes,
// predicts every access of each accepted command and compares the result strobes.
// Depends on salc_pkg for the code and width constants.
`timescale 1ns / 1ps

module salc_access_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_valid,
    input  wire                             i_cfg_ready,
    input  wire  [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [salc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire                             i_start,
    input  wire                             i_busy,
    input  wire  [salc_pkg::OP_W-1:0]       i_operation,
    input  wire  [salc_pkg::ADDR_W-1:0]     i_address,
    input  wire                             i_result_valid,
    input  wire  [salc_pkg::OUTCOME_W-1:0]  i_outcome,
    input  wire                             i_last,
    input  wire  [salc_pkg::CNT_W-1:0]      i_hit_total,
    input  wire  [salc_pkg::CNT_W-1:0]      i_miss_total,
    input  wire  [salc_pkg::CNT_W-1:0]      i_evict_total,
    output int                              o_fail_count,
    output int                              o_pending,
    output int                              o_checked
);

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int NUM_LINES    = (1 << MAX_SET_BITS) * MAX_WAYS;
    localparam int PRINT_LIMIT  = 40;

    typedef struct packed {
        logic [salc_pkg::OUTCOME_W-1:0] outcome;
        logic                           last;
        logic [salc_pkg::CNT_W-1:0]     hits;
        logic [salc_pkg::CNT_W-1:0]     misses;
        logic [salc_pkg::CNT_W-1:0]     evicts;
    } t_access_result;

    t_access_result expected_results[$];
    t_access_result oldest;

    // mirror of the line store, totals and config registers
    logic                       line_valid [NUM_LINES];
    logic [salc_pkg::TAG_W-1:0] line_tag   [NUM_LINES];
    logic [2:0]                 line_rank  [NUM_LINES];
    logic [salc_pkg::CNT_W-1:0] hit_count, miss_count, evict_count;
    logic [2:0]                 cfg_set_bits;
    logic [5:0]                 cfg_block_bits;
    logic [3:0]                 cfg_ways;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        o_fail_count++;
        if (o_fail_count <= PRINT_LIMIT)
            $display("[%0t] %s: expected %0h, observed %0h", $time, what, want, got);
    endtask

    // one lookup with fill and LRU aging; returns the outcome code
    function automatic logic [salc_pkg::OUTCOME_W-1:0] cache_access(
            input logic [salc_pkg::ADDR_W-1:0] addr);
        int                             sb, bb, nw, tshift, set_idx, base, target;
        int                             old_rank, best;
        logic [salc_pkg::TAG_W-1:0]     tag;
        logic                           found;
        logic [salc_pkg::OUTCOME_W-1:0] outcome;
        sb      = (cfg_set_bits > MAX_SET_BITS) ? MAX_SET_BITS : int'(cfg_set_bits);
        bb      = int'(cfg_block_bits);
        nw      = (cfg_ways == 0) ? 1 : ((cfg_ways > MAX_WAYS) ? MAX_WAYS : int'(cfg_ways));
        tshift  = sb + bb;
        tag     = (tshift >= 64) ? '0 : (addr >> tshift);
        set_idx = int'((addr >> bb) & ((64'd1 << sb) - 64'd1));
        base    = set_idx * MAX_WAYS;
        target  = 0;
        old_rank = MAX_WAYS;
        found   = 1'b0;
        for (int w = 0; w < nw && !found; w++) begin
            if (line_valid[base+w] && line_tag[base+w] == tag) begin
                found    = 1'b1;
                target   = w;
                old_rank = int'(line_rank[base+w]);
            end
        end
        if (found) begin
            outcome = salc_pkg::OUT_HIT;
        end else begin
            // free line first, else the oldest valid line
            for (int w = 0; w < nw && !found; w++) begin
                if (!line_valid[base+w]) begin
                    found  = 1'b1;
                    target = w;
                end
            end
            if (found) begin
                outcome = salc_pkg::OUT_MISS;
            end else begin
                best   = 0;
                target = 0;
                for (int w = 0; w < nw; w++) begin
                    if (int'(line_rank[base+w]) > best) begin
                        best   = int'(line_rank[base+w]);
                        target = w;
                    end
                end
                outcome = salc_pkg::OUT_EVICT;
            end
            line_valid[base+target] = 1'b1;
            line_tag[base+target]   = tag;
            old_rank = MAX_WAYS;
        end
        // age lines that were more recent than the touched one, saturating
        for (int w = 0; w < nw; w++) begin
            if (w != target && line_valid[base+w] && int'(line_rank[base+w]) < old_rank
                && int'(line_rank[base+w]) < MAX_WAYS - 1)
                line_rank[base+w] = line_rank[base+w] + 3'd1;
        end
        line_rank[base+target] = '0;
        if (outcome == salc_pkg::OUT_HIT) begin
            hit_count++;
        end else begin
            miss_count++;
            if (outcome == salc_pkg::OUT_EVICT)
                evict_count++;
        end
        return outcome;
    endfunction

    // expected results of one command: two accesses for a modify, else one
    task automatic predict_item(input logic [salc_pkg::OP_W-1:0] op,
                                input logic [salc_pkg::ADDR_W-1:0] addr);
        t_access_result r;
        if (op == salc_pkg::OP_MODIFY) begin
            r.outcome = cache_access(addr);
            r.last    = 1'b0;
            r.hits    = hit_count;
            r.misses  = miss_count;
            r.evicts  = evict_count;
            expected_results.push_back(r);
        end
        r.outcome = cache_access(addr);
        r.last    = 1'b1;
        r.hits    = hit_count;
        r.misses  = miss_count;
        r.evicts  = evict_count;
        expected_results.push_back(r);
    endtask

    // watch config writes, results and accepted commands
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LINES; i++) begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_rank[i]  = '0;
            end
            hit_count      = '0;
            miss_count     = '0;
            evict_count    = '0;
            cfg_set_bits   = 3'd0;
            cfg_block_bits = 6'd0;
            cfg_ways       = 4'd1;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    salc_pkg::CFG_SET_BITS:   cfg_set_bits   = i_cfg_data[2:0];
                    salc_pkg::CFG_BLOCK_BITS: cfg_block_bits = i_cfg_data[5:0];
                    salc_pkg::CFG_WAYS:       cfg_ways       = i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (i_result_valid) begin
                o_checked++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no access pending", 64'd0,
                                    64'(i_outcome));
                end else begin
                    oldest = expected_results.pop_front();
                    if (i_outcome !== oldest.outcome)
                        report_mismatch("outcome", 64'(oldest.outcome), 64'(i_outcome));
                    if (i_last !== oldest.last)
                        report_mismatch("last", 64'(oldest.last), 64'(i_last));
                    if (i_hit_total !== oldest.hits)
                        report_mismatch("hit total", 64'(oldest.hits), 64'(i_hit_total));
                    if (i_miss_total !== oldest.misses)
                        report_mismatch("miss total", 64'(oldest.misses),
                                        64'(i_miss_total));
                    if (i_evict_total !== oldest.evicts)
                        report_mismatch("evict total", 64'(oldest.evicts),
                                        64'(i_evict_total));
                end
            end
            if (i_start && !i_busy)
                predict_item(i_operation, i_address);
        end
        o_pending = expected_results.size();
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the cache testbench: clock, reset, command and config stimulus, verdict.
// Depends on salc_pkg, set_assoc_lru_cache_sim and salc_access_checker.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int PHASE_ITEMS  = 50;
    localparam int FIXED_PHASES = 7;
    localparam int NUM_PHASES   = 9;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [salc_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [salc_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_start;
    logic                            o_busy;
    logic [salc_pkg::OP_W-1:0]       i_operation;
    logic [salc_pkg::ADDR_W-1:0]     i_address;
    logic                            o_result_valid;
    logic [salc_pkg::OUTCOME_W-1:0]  o_outcome;
    logic                            o_last;
    logic [salc_pkg::CNT_W-1:0]      o_hit_total;
    logic [salc_pkg::CNT_W-1:0]      o_miss_total;
    logic [salc_pkg::CNT_W-1:0]      o_evict_total;

    int fail_count, pending, checked;
    int cycle_count;
    int items_sent;

    // stimulus view of the current setting
    int                         eff_sb, eff_bb, eff_nw;
    int                         pool_n;
    logic [salc_pkg::TAG_W-1:0] tag_pool [16];

    // fixed settings: plain, largest, over-range, zero ways, stray upper data bits,
    // and a tag shift of exactly 64
    logic [5:0] tbl_sets  [FIXED_PHASES] = '{6'd2, 6'd6, 6'd7, 6'd0, 6'b111011, 6'd1, 6'd6};
    logic [5:0] tbl_block [FIXED_PHASES] = '{6'd4, 6'd32, 6'd63, 6'd0, 6'd6, 6'd12, 6'd58};
    logic [5:0] tbl_ways  [FIXED_PHASES] = '{6'd4, 6'd8, 6'd15, 6'd0, 6'b110010, 6'd8, 6'd5};

    set_assoc_lru_cache_sim dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .o_busy         (o_busy),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .o_result_valid (o_result_valid),
        .o_outcome      (o_outcome),
        .o_last         (o_last),
        .o_hit_total    (o_hit_total),
        .o_miss_total   (o_miss_total),
        .o_evict_total  (o_evict_total)
    );

    salc_access_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_start        (i_start),
        .i_busy         (o_busy),
        .i_operation    (i_operation),
        .i_address      (i_address),
        .i_result_valid (o_result_valid),
        .i_outcome      (o_outcome),
        .i_last         (o_last),
        .i_hit_total    (o_hit_total),
        .i_miss_total   (o_miss_total),
        .i_evict_total  (o_evict_total),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_checked      (checked)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // run-away guard
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // drive one command and hold it until accepted; start is left high
    task automatic send_item(input logic [salc_pkg::OP_W-1:0] op,
                             input logic [salc_pkg::ADDR_W-1:0] addr);
        i_start     <= 1'b1;
        i_operation <= op;
        i_address   <= addr;
        do @(posedge i_clk); while (o_busy);
        items_sent++;
        @(negedge i_clk);
    endtask

    // one register write; valid is left high for back-to-back writes
    task automatic cfg_write(input logic [salc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [5:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // write all three registers and build a tag pool sized around the way count
    task automatic apply_config(input logic [5:0] sb_data, input logic [5:0] bb_data,
                                input logic [5:0] ways_data);
        cfg_write(salc_pkg::CFG_SET_BITS, sb_data);
        cfg_write(salc_pkg::CFG_BLOCK_BITS, bb_data);
        cfg_write(salc_pkg::CFG_WAYS, ways_data);
        i_cfg_valid <= 1'b0;
        eff_sb = (sb_data[2:0] > 6) ? 6 : int'(sb_data[2:0]);
        eff_bb = int'(bb_data);
        eff_nw = (ways_data[3:0] == 0) ? 1 : ((ways_data[3:0] > 8) ? 8 : int'(ways_data[3:0]));
        pool_n = eff_nw + $urandom_range(0, 3);
        for (int i = 0; i < 16; i++)
            tag_pool[i] = {$urandom, $urandom};
    endtask

    // address from the tag pool, one of a few sets, random offset
    function automatic logic [salc_pkg::ADDR_W-1:0] pool_address();
        logic [63:0] tag_part, set_part, offset_mask, noise;
        tag_part    = tag_pool[$urandom_range(0, pool_n - 1)] << (eff_sb + eff_bb);
        set_part    = (64'($urandom_range(0, 3)) & ((64'd1 << eff_sb) - 64'd1)) << eff_bb;
        offset_mask = (64'd1 << eff_bb) - 64'd1;
        noise       = {$urandom, $urandom};
        return tag_part | set_part | (noise & offset_mask);
    endfunction

    // random commands; idle_pct is the chance of a gap after each command
    task automatic run_phase(input int n, input int idle_pct);
        logic [salc_pkg::OP_W-1:0]   op;
        logic [salc_pkg::ADDR_W-1:0] addr;
        for (int i = 0; i < n; i++) begin
            op   = salc_pkg::OP_W'($urandom_range(0, 3));
            addr = ($urandom_range(0, 99) < 85) ? pool_address() : {$urandom, $urandom};
            send_item(op, addr);
            if ($urandom_range(0, 99) < idle_pct) begin
                i_start <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge i_clk);
            end
        end
        i_start <= 1'b0;
        wait_drained();
    endtask

    initial begin
        int idle_pct;
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = salc_pkg::CFG_SET_BITS;
        i_cfg_data  = '0;
        i_start     = 1'b0;
        i_operation = salc_pkg::OP_LOAD;
        i_address   = '0;
        cycle_count = 0;
        items_sent  = 0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting, one way, full-address tags: fill, hit, evict, modify, code three
        send_item(salc_pkg::OP_LOAD, 64'h0);
        send_item(salc_pkg::OP_LOAD, 64'h0);
        send_item(salc_pkg::OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(salc_pkg::OP_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(salc_pkg::OP_MODIFY, 64'h0);
        send_item(salc_pkg::OP_W'(3), 64'h0);
        send_item(salc_pkg::OP_LOAD, 64'h8000_0000_0000_0000);
        send_item(salc_pkg::OP_STORE, 64'h5555_5555_5555_5555);
        send_item(salc_pkg::OP_MODIFY, 64'hAAAA_AAAA_AAAA_AAAA);
        i_start <= 1'b0;
        wait_drained();

        // settings sweep, lines kept across changes; idling varies by phase
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p < FIXED_PHASES)
                apply_config(tbl_sets[p], tbl_block[p], tbl_ways[p]);
            else
                apply_config(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                             6'($urandom_range(0, 63)));
            case (p % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 57;
                default: idle_pct = 16;
            endcase
            run_phase(PHASE_ITEMS, idle_pct);
        end

        while (pending != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        $display("Sent %0d commands over %0d settings and checked %0d access results.",
                 items_sent, NUM_PHASES + 1, checked);
        $display("Settings covered over-range set bits and ways, zero ways, tag shift >= 64.");
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
